[rtl/core/mra_pkg.sv]
// Shared types, widths, register indexes and saturation helper for the masked recursive average.
package mra_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int WLEN_W     = 7;
    localparam int LOOK_W     = 6;
    localparam int MINC_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID_COUNT = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RST = 7'd8;
    localparam logic [LOOK_W-1:0] LOOK_RST = 6'd1;
    localparam logic [MINC_W-1:0] MINC_RST = 7'd1;

    // Datapath widths
    localparam int COUNT_W   = 16;
    localparam int INDEX_W   = 16;
    localparam int ACC_W     = 64;
    localparam int AVG_W     = 32;
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 16;
    localparam int WIDE_W    = 52;

    localparam logic signed [ACC_W-1:0]  SUM_CLAMP = 64'sd1099511627776;
    localparam logic signed [WIDE_W-1:0] AVG_MAX   = 52'sd2147483647;
    localparam logic signed [WIDE_W-1:0] AVG_MIN   = -52'sd2147483648;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    // Saturate a wide signed value to the average range
    function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        begin
            if (v > AVG_MAX)
            begin
                c = AVG_MAX;
            end
            else if (v < AVG_MIN)
            begin
                c = AVG_MIN;
            end
            else
            begin
                c = v;
            end
            return c[AVG_W-1:0];
        end
    endfunction

endpackage

[rtl/core/mra_in_if.sv]
// Input sample channel: valid/ready plus sample payload.
interface mra_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          last_in;

    modport source (output valid, sample, sample_valid, last_in, input ready);
    modport sink   (input valid, sample, sample_valid, last_in, output ready);
endinterface

[rtl/core/mra_out_if.sv]
// Output average channel: valid/ready plus average payload.
interface mra_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] average;
    logic               average_valid;
    logic               last_out;

    modport source (output valid, average, average_valid, last_out, input ready);
    modport sink   (input valid, average, average_valid, last_out, output ready);
endinterface

[rtl/core/mra_ram.sv]
// Generic simple dual-port RAM with registered read.
module mra_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/mra_div.sv]
// Rounded unsigned divider, restoring, one quotient bit per cycle.
module mra_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mra_pkg::div_req_t  req,
    output mra_pkg::div_rsp_t  rsp
);
    import mra_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] dvd_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.num + DIV_NUM_W'(req.den >> 1);
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;
endmodule

[rtl/core/masked_recursive_average.sv]
// Top level: masked recursive average with window sums, history RAM and shared divider.
//
//  channel      dir  handshake       payload
//  sample_ch    in   valid/ready     sample, sample_valid, last_in
//  average_ch   out  valid/ready     average, average_valid, last_out
//  cfg          in   cfg_we          cfg_index, cfg_data (write only)
//
// An item without results passes the add, subtract, plan and finish states before input
// is ready again. A recursion result reads the history (request, wait, evaluate), then
// emits, passing through the divider when it divides; the window mean divides once and
// its copies over the first half window go out one per cycle unless the output stalls.
// Reset clears control state; the history RAM is not cleared (never read unwritten).
// A stalled output holds the sequencer in an emit state; input is taken only when idle.
module masked_recursive_average #(
    parameter int MAX_WINDOW   = 64,
    parameter int MAX_LOOKBACK = 32,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mra_in_if.sink                       sample_ch,
    mra_out_if.source                    average_ch,
    input  logic                         cfg_we,
    input  logic [mra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mra_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mra_pkg::*;

    localparam int HIST_DEPTH = 2 ** $clog2(MAX_WINDOW + MAX_LOOKBACK + 1);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HIST_W     = SAMPLE_BITS + 1;
    localparam logic [WLEN_W-1:0] W_CAP = WLEN_W'(MAX_WINDOW > 127 ? 127 : MAX_WINDOW);
    localparam logic [LOOK_W-1:0] L_CAP = LOOK_W'(MAX_LOOKBACK > 63 ? 63 : MAX_LOOKBACK);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ADD   = 4'd1;
    localparam logic [3:0] ST_SUB   = 4'd2;
    localparam logic [3:0] ST_PLAN  = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_SEG   = 4'd5;
    localparam logic [3:0] ST_RREQ  = 4'd6;
    localparam logic [3:0] ST_RWAIT = 4'd7;
    localparam logic [3:0] ST_REVAL = 4'd8;
    localparam logic [3:0] ST_REMIT = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    // Registers
    logic [3:0]                    state_reg;
    logic [WLEN_W-1:0]             wlen_reg;
    logic [LOOK_W-1:0]             look_reg;
    logic [MINC_W-1:0]             minc_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          v_reg;
    logic                          last_reg;
    logic [ACC_W-1:0]              sum_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [INDEX_W-1:0]            index_reg;
    logic [HIST_AW-1:0]            wr_pos_reg;
    logic [HIST_AW-1:0]            rd_addr_reg;
    logic signed [AVG_W-1:0]       prev_reg;
    logic                          init_reg;
    logic [WLEN_W-1:0]             d_reg;
    logic [WLEN_W-1:0]             seg_reg;
    logic                          tail_reg;
    logic                          recur_mode_reg;
    logic                          recur_div_reg;
    logic                          neg_reg;
    logic signed [AVG_W-1:0]       avg_reg;
    logic                          ok_reg;
    logic                          ov_reg;
    logic signed [AVG_W-1:0]       oavg_reg;
    logic                          ook_reg;
    logic                          olast_reg;

    // Combinational
    logic [WLEN_W-1:0]             w;
    logic [LOOK_W-1:0]             l;
    logic [LOOK_W-1:0]             s;
    logic [LOOK_W-1:0]             e;
    logic [INDEX_W:0]              j1;
    logic                          grp_a;
    logic                          full;
    logic                          enough;
    logic                          accept;
    logic                          out_free;
    logic [HIST_W-1:0]             rdata;
    logic signed [SAMPLE_BITS-1:0] rd_x;
    logic                          rd_ok;
    logic [7:0]                    lag_off;
    logic                          lag_ok;
    logic signed [ACC_W-1:0]       sum_sig;
    logic signed [ACC_W-1:0]       sum_clamp;
    logic signed [ACC_W-1:0]       sum_abs;
    logic [DIV_NUM_W-1:0]          mean_mag;
    logic signed [WIDE_W-1:0]      diff;
    logic signed [WIDE_W-1:0]      diff_abs;
    logic signed [WIDE_W-1:0]      q_wide;
    logic signed [WIDE_W-1:0]      q_signed;
    logic signed [AVG_W-1:0]       div_avg;
    logic                          start_mean;
    logic                          start_recur;
    div_req_t                      div_req;
    div_rsp_t                      div_rsp;

    // Window geometry from current registers
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            w = WLEN_W'(1);
        end
        else if (wlen_reg > W_CAP)
        begin
            w = W_CAP;
        end
        else
        begin
            w = wlen_reg;
        end
        l     = (look_reg > L_CAP) ? L_CAP : look_reg;
        s     = w[WLEN_W-1:1];
        e     = w[0] ? s : s - 1'b1;
        j1    = {1'b0, index_reg} + 1'b1;
        grp_a = j1 <= (INDEX_W+1)'(w);
        full  = j1 == (INDEX_W+1)'(w);
    end

    assign enough   = count_reg >= COUNT_W'(minc_reg);
    assign accept   = sample_ch.valid && sample_ch.ready;
    assign out_free = !ov_reg || average_ch.ready;
    assign rd_x     = signed'(rdata[SAMPLE_BITS-1:0]);
    assign rd_ok    = rdata[HIST_W-1];
    assign lag_off  = 8'(d_reg) + 8'(l);
    assign lag_ok   = (index_reg >= INDEX_W'(lag_off)) && rd_ok;

    // Clamped window sum scaled to eight fraction bits
    always_comb
    begin
        sum_sig = signed'(sum_reg);
        if (sum_sig > SUM_CLAMP)
        begin
            sum_clamp = SUM_CLAMP;
        end
        else if (sum_sig < -SUM_CLAMP)
        begin
            sum_clamp = -SUM_CLAMP;
        end
        else
        begin
            sum_clamp = sum_sig;
        end
        sum_abs  = (sum_clamp < 0) ? -sum_clamp : sum_clamp;
        mean_mag = {sum_abs[40:0], 8'b0};
    end

    // Recursion difference: lagged sample minus previous average
    always_comb
    begin
        diff     = (WIDE_W'(rd_x) <<< 8) - WIDE_W'(prev_reg);
        diff_abs = (diff < 0) ? -diff : diff;
    end

    // Divider launch
    always_comb
    begin
        start_mean  = 1'b0;
        start_recur = 1'b0;
        case (state_reg)
            ST_PLAN:
            begin
                start_mean = grp_a && (full || last_reg) && enough && (count_reg != '0);
            end
            ST_REVAL:
            begin
                start_mean  = init_reg && enough && (count_reg != '0);
                start_recur = !init_reg && lag_ok;
            end
            default:
            begin
                start_mean  = 1'b0;
                start_recur = 1'b0;
            end
        endcase
        div_req.start = start_mean || start_recur;
        div_req.num   = start_recur ? diff_abs[DIV_NUM_W-1:0] : mean_mag;
        div_req.den   = start_recur ? DIV_DEN_W'(w) : count_reg;
    end

    // Signed, saturated divider result
    always_comb
    begin
        q_wide   = signed'(WIDE_W'(div_rsp.quot));
        q_signed = neg_reg ? -q_wide : q_wide;
        div_avg  = recur_div_reg ? sat_avg(WIDE_W'(prev_reg) + q_signed) : sat_avg(q_signed);
    end

    mra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mra_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_pos_reg),
        .wdata ({sample_ch.sample_valid, sample_ch.sample}),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RST;
            look_reg <= LOOK_RST;
            minc_reg <= MINC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH:   wlen_reg <= cfg_data;
                CFG_LOOKBACK:        look_reg <= cfg_data[LOOK_W-1:0];
                CFG_MIN_VALID_COUNT: minc_reg <= cfg_data;
                default:             wlen_reg <= wlen_reg;
            endcase
        end
    end

    // Sequencer and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sum_reg        <= '0;
            count_reg      <= '0;
            index_reg      <= '0;
            wr_pos_reg     <= '0;
            rd_addr_reg    <= '0;
            prev_reg       <= '0;
            init_reg       <= 1'b0;
            d_reg          <= '0;
            seg_reg        <= '0;
            tail_reg       <= 1'b0;
            recur_mode_reg <= 1'b0;
            recur_div_reg  <= 1'b0;
            neg_reg        <= 1'b0;
            ov_reg         <= 1'b0;
            last_reg       <= 1'b0;
            v_reg          <= 1'b0;
        end
        else
        begin
            if (average_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (div_req.start)
            begin
                recur_div_reg <= start_recur;
                neg_reg       <= start_recur ? (diff < 0) : (sum_clamp < 0);
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg       <= sample_ch.sample;
                        v_reg       <= sample_ch.sample_valid;
                        last_reg    <= sample_ch.last_in;
                        rd_addr_reg <= wr_pos_reg - HIST_AW'(w);
                        state_reg   <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (v_reg)
                    begin
                        sum_reg   <= sum_reg + ACC_W'(x_reg);
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_SUB;
                end
                ST_SUB:
                begin
                    // Drop the sample leaving the window
                    if ((index_reg >= INDEX_W'(w)) && rd_ok)
                    begin
                        sum_reg   <= sum_reg - ACC_W'(rd_x);
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= ST_PLAN;
                end
                ST_PLAN:
                begin
                    if (grp_a)
                    begin
                        if (full || last_reg)
                        begin
                            recur_mode_reg <= 1'b0;
                            seg_reg  <= full ? WLEN_W'(s) + 1'b1 : WLEN_W'(j1);
                            tail_reg <= full && last_reg && (INDEX_W'(s) + 1'b1 <= index_reg);
                            d_reg    <= w - WLEN_W'(s) - WLEN_W'(2);
                            init_reg <= !enough;
                            ok_reg   <= enough;
                            if (start_mean)
                            begin
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                avg_reg   <= '0;
                                prev_reg  <= '0;
                                state_reg <= ST_SEG;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                    else
                    begin
                        recur_mode_reg <= 1'b1;
                        d_reg          <= WLEN_W'(e);
                        state_reg      <= ST_RREQ;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        avg_reg   <= div_avg;
                        prev_reg  <= div_avg;
                        state_reg <= recur_mode_reg ? ST_REMIT : ST_SEG;
                    end
                end
                ST_SEG:
                begin
                    // Repeat the window mean over the first half window
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        oavg_reg  <= avg_reg;
                        ook_reg   <= ok_reg;
                        olast_reg <= last_reg && (seg_reg == WLEN_W'(1)) && !tail_reg;
                        seg_reg   <= seg_reg - 1'b1;
                        if (seg_reg == WLEN_W'(1))
                        begin
                            recur_mode_reg <= 1'b1;
                            state_reg      <= tail_reg ? ST_RREQ : ST_FIN;
                        end
                    end
                end
                ST_RREQ:
                begin
                    rd_addr_reg <= wr_pos_reg - HIST_AW'(lag_off);
                    state_reg   <= ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    state_reg <= ST_REVAL;
                end
                ST_REVAL:
                begin
                    if (init_reg)
                    begin
                        if (enough)
                        begin
                            init_reg <= 1'b0;
                            ok_reg   <= 1'b1;
                            if (start_mean)
                            begin
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                avg_reg   <= '0;
                                prev_reg  <= '0;
                                state_reg <= ST_REMIT;
                            end
                        end
                        else
                        begin
                            avg_reg   <= '0;
                            ok_reg    <= 1'b0;
                            prev_reg  <= '0;
                            state_reg <= ST_REMIT;
                        end
                    end
                    else if (lag_ok)
                    begin
                        ok_reg    <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                    else if (enough)
                    begin
                        avg_reg   <= prev_reg;
                        ok_reg    <= 1'b1;
                        state_reg <= ST_REMIT;
                    end
                    else
                    begin
                        avg_reg   <= '0;
                        ok_reg    <= 1'b0;
                        prev_reg  <= '0;
                        init_reg  <= 1'b1;
                        state_reg <= ST_REMIT;
                    end
                end
                ST_REMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        oavg_reg  <= avg_reg;
                        ook_reg   <= ok_reg;
                        olast_reg <= last_reg && (d_reg == '0);
                        if (last_reg && (d_reg != '0))
                        begin
                            d_reg     <= d_reg - 1'b1;
                            state_reg <= ST_RREQ;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN:
                begin
                    wr_pos_reg <= wr_pos_reg + 1'b1;
                    if (last_reg)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        index_reg <= '0;
                        prev_reg  <= '0;
                        init_reg  <= 1'b0;
                    end
                    else if (index_reg != {INDEX_W{1'b1}})
                    begin
                        index_reg <= index_reg + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Ports
    assign sample_ch.ready          = (state_reg == ST_IDLE);
    assign average_ch.valid         = ov_reg;
    assign average_ch.average       = oavg_reg;
    assign average_ch.average_valid = ook_reg;
    assign average_ch.last_out      = olast_reg;

    // Checks
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (average_ch.valid && !average_ch.average_valid) |-> (average_ch.average == '0))
        else $error("undefined average not zero");

    a_record_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && last_reg) |=>
            ((sum_reg == '0) && (count_reg == '0) && (index_reg == '0)))
        else $error("record state not cleared after last sample");
endmodule
